[sv/ipv6at_pkg.sv]
// Package: shared types, character constants and hex helper for the IPv6 text formatter.
`default_nettype none

package ipv6at_pkg;

  localparam int unsigned NumGroups = 8;

  localparam logic [6:0] ChrColon = 7'h3A;
  localparam logic [6:0] ChrZero  = 7'h30;
  localparam logic [6:0] ChrUpperA = 7'h41;

  // Per-group findings of one lane
  typedef struct packed {
    logic            zero;       // whole group is zero
    logic [1:0]      first_dig;  // first printed digit, 0 = most significant
    logic [3:0][6:0] chr;        // ASCII of each digit, index 0 = most significant
  } lane_info_t;

  // Longest zero run of one address
  typedef struct packed {
    logic [2:0] start;
    logic [3:0] len;
  } run_t;

  // Character sequencer states
  typedef enum logic [2:0] {
    EM_IDLE,
    EM_SEP,
    EM_DIG,
    EM_DC1,
    EM_DC2
  } em_state_e;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] res;
    if (nib < 4'd10) begin
      res = ChrZero + {3'b000, nib};
    end else begin
      res = ChrUpperA + {3'b000, nib} - 7'd10;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/ipv6at_in_if.sv]
// Interface: address request channel (two 64-bit halves, valid/ready).
`default_nettype none

interface ipv6at_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] addr_high;
  logic [63:0] addr_low;

  modport source (output valid, output addr_high, output addr_low, input ready);
  modport sink   (input valid, input addr_high, input addr_low, output ready);
endinterface

`default_nettype wire

[sv/ipv6at_out_if.sv]
// Interface: text character channel (one ASCII character per request, valid/ready).
`default_nettype none

interface ipv6at_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

[sv/ipv6at_lane.sv]
// Lane: formats one 16-bit group into hex characters and finds its leading digit.
`default_nettype none

module ipv6at_lane (
  input  logic [15:0]             group_i,
  output ipv6at_pkg::lane_info_t  info_o
);
  import ipv6at_pkg::*;

  logic [3:0] nz;

  // Nibble nonzero flags, most significant first
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      nz[d] = |group_i[15 - 4*d -: 4];
    end
  end

  always_comb begin
    info_o.zero = ~|nz;
    priority if (nz[0]) begin
      info_o.first_dig = 2'd0;
    end else if (nz[1]) begin
      info_o.first_dig = 2'd1;
    end else if (nz[2]) begin
      info_o.first_dig = 2'd2;
    end else begin
      info_o.first_dig = 2'd3;
    end
    for (int d = 0; d < 4; d++) begin
      info_o.chr[d] = hex_char(group_i[15 - 4*d -: 4]);
    end
  end

endmodule

`default_nettype wire

[sv/ipv6at_merge.sv]
// Merge: combines the lanes' zero flags into the first longest run of zero groups.
`default_nettype none

module ipv6at_merge (
  input  ipv6at_pkg::lane_info_t [ipv6at_pkg::NumGroups-1:0] info_i,
  output ipv6at_pkg::run_t                                   run_o
);
  import ipv6at_pkg::*;

  logic [3:0] cur;
  logic [3:0] best_len;
  logic [2:0] best_start;

  // Left-to-right scan; a strictly longer run replaces the best, so ties keep the first
  always_comb begin
    cur        = 4'd0;
    best_len   = 4'd0;
    best_start = 3'd0;
    for (int i = 0; i < NumGroups; i++) begin
      if (info_i[i].zero) begin
        cur = cur + 4'd1;
      end else begin
        if (cur > best_len) begin
          best_len   = cur;
          best_start = 3'(4'(i) - cur);
        end
        cur = 4'd0;
      end
    end
    // Run that reaches the last group
    if (cur > best_len) begin
      best_len   = cur;
      best_start = 3'(4'(NumGroups) - cur);
    end
    run_o.start = best_start;
    run_o.len   = best_len;
  end

endmodule

`default_nettype wire

[sv/ipv6at_emit.sv]
// Emitter: walks the groups of one address and sends its text one character per cycle while the output accepts it.
`default_nettype none

module ipv6at_emit (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               load_i,
  input  ipv6at_pkg::lane_info_t [ipv6at_pkg::NumGroups-1:0] info_i,
  input  ipv6at_pkg::run_t                                   run_i,
  output logic                                               free_o,
  ipv6at_out_if.source                                       out_o
);
  import ipv6at_pkg::*;

  em_state_e  state_q, state_d;
  logic [2:0] gi_q, gi_d;
  logic [1:0] di_q, di_d;
  lane_info_t [NumGroups-1:0] info_q, info_d;
  run_t       run_q, run_d;

  logic       o_vld_q, o_vld_d;
  logic [6:0] o_chr_q, o_chr_d;
  logic       o_last_q, o_last_d;

  logic       busy, step, is_last, run_at_end;
  logic [6:0] chr;
  logic [2:0] gi_inc;
  logic [2:0] gi_after_run;

  assign busy         = (state_q != EM_IDLE);
  assign step         = busy && (!o_vld_q || out_o.ready);
  assign run_at_end   = (({1'b0, run_q.start} + run_q.len) == 4'(NumGroups));
  assign gi_inc       = gi_q + 3'd1;
  assign gi_after_run = run_q.start + run_q.len[2:0];
  assign free_o       = !busy || (step && is_last);

  // Next state of the character walk
  always_comb begin
    state_d = state_q;
    gi_d    = gi_q;
    di_d    = di_q;
    info_d  = info_q;
    run_d   = run_q;
    if (step) begin
      unique case (state_q)
        EM_SEP: begin
          state_d = EM_DIG;
          di_d    = info_q[gi_q].first_dig;
        end
        EM_DIG: begin
          if (di_q == 2'd3) begin
            if (gi_q == 3'(NumGroups - 1)) begin
              state_d = EM_IDLE;
            end else begin
              gi_d = gi_inc;
              if (run_q.len != 4'd0 && gi_inc == run_q.start) begin
                state_d = EM_DC1;
              end else begin
                state_d = EM_SEP;
              end
            end
          end else begin
            di_d = di_q + 2'd1;
          end
        end
        EM_DC1: begin
          state_d = EM_DC2;
        end
        EM_DC2: begin
          if (run_at_end) begin
            state_d = EM_IDLE;
          end else begin
            state_d = EM_DIG;
            gi_d    = gi_after_run;
            di_d    = info_q[gi_after_run].first_dig;
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
    // New address; only taken when idle or on its predecessor's last character
    if (load_i) begin
      info_d = info_i;
      run_d  = run_i;
      gi_d   = 3'd0;
      di_d   = info_i[0].first_dig;
      if (run_i.len != 4'd0 && run_i.start == 3'd0) begin
        state_d = EM_DC1;
      end else begin
        state_d = EM_DIG;
      end
    end
  end

  // Character of the current step
  always_comb begin
    unique case (state_q)
      EM_DIG: begin
        chr     = info_q[gi_q].chr[di_q];
        is_last = (di_q == 2'd3) && (gi_q == 3'(NumGroups - 1));
      end
      EM_DC2: begin
        chr     = ChrColon;
        is_last = run_at_end;
      end
      EM_SEP, EM_DC1: begin
        chr     = ChrColon;
        is_last = 1'b0;
      end
      default: begin
        chr     = ChrColon;
        is_last = 1'b0;
      end
    endcase
  end

  // Output register
  always_comb begin
    o_vld_d  = o_vld_q;
    o_chr_d  = o_chr_q;
    o_last_d = o_last_q;
    if (step) begin
      o_vld_d  = 1'b1;
      o_chr_d  = chr;
      o_last_d = is_last;
    end else if (out_o.ready) begin
      o_vld_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EM_IDLE;
      gi_q    <= 3'd0;
      di_q    <= 2'd0;
      o_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      gi_q    <= gi_d;
      di_q    <= di_d;
      o_vld_q <= o_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    info_q   <= info_d;
    run_q    <= run_d;
    o_chr_q  <= o_chr_d;
    o_last_q <= o_last_d;
  end

  assign out_o.valid     = o_vld_q;
  assign out_o.char_code = o_chr_q;
  assign out_o.last_char = o_last_q;

endmodule

`default_nettype wire

[sv/ipv6_address_to_text.sv]
// Top level: IPv6 address to compressed uppercase text, one character per cycle while the output accepts it.
//
// Each accepted address produces 2 to 39 characters (uppercase hex groups, colons, and
// "::" in place of the first longest run of zero groups), with last_char set on the
// final one. The character emitter sends one character per cycle while the output is
// not stalled. Eight lanes format the groups in the cycle an address is accepted; the
// next address waits in an input stage and its first character follows the previous
// address's last character with no gap. An empty input stage takes a request even
// while a character waits in the output register; a full one frees only when the
// emitter loads it, which a stalled output holds back.
`default_nettype none

module ipv6_address_to_text (
  input  logic          clk_i,
  input  logic          rst_ni,
  ipv6at_in_if.sink     in_i,
  ipv6at_out_if.source  out_o
);
  import ipv6at_pkg::*;

  lane_info_t [NumGroups-1:0] lane_info;
  lane_info_t [NumGroups-1:0] s1_info_q;
  logic                       s1_vld_q, s1_vld_d;
  run_t                       s1_run;
  logic                       em_free, em_load, accept;

  // One lane per 16-bit group, group 0 in the top bits of addr_high
  for (genvar g = 0; g < NumGroups / 2; g++) begin : g_lane
    ipv6at_lane u_lane_hi (
      .group_i (in_i.addr_high[63 - 16*g -: 16]),
      .info_o  (lane_info[g])
    );
    ipv6at_lane u_lane_lo (
      .group_i (in_i.addr_low[63 - 16*g -: 16]),
      .info_o  (lane_info[g + NumGroups / 2])
    );
  end

  // Input stage holding the lanes' findings
  assign em_load   = s1_vld_q && em_free;
  assign in_i.ready = !s1_vld_q || em_load;
  assign accept    = in_i.valid && in_i.ready;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (em_load) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= lane_info;
    end
  end

  // Zero-run search across the lanes
  ipv6at_merge u_merge (
    .info_i (s1_info_q),
    .run_o  (s1_run)
  );

  ipv6at_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (em_load),
    .info_i (s1_info_q),
    .run_i  (s1_run),
    .free_o (em_free),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
